// File: sv/sliding_window_minimizer_macros.svh
// Assertion macros for the window minimizer, used by swm_back
`ifndef SLIDING_WINDOW_MINIMIZER_MACROS_SVH
`define SLIDING_WINDOW_MINIMIZER_MACROS_SVH

// implication checked on every clock edge outside reset
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Types, constants and the masked hash for the window minimizer.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned MaxWindow = 32;
  localparam int unsigned SlotW     = $clog2(MaxWindow);
  localparam int unsigned CntW      = $clog2(MaxWindow + 1);
  localparam int unsigned QDepth    = 2;

  localparam logic [0:0] RegKmerLen = 1'b0;
  localparam logic [0:0] RegWinSize = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    logic             seq_start;
    logic [63:0]      kmer;
    logic [63:0]      hash;
    logic [31:0]      rank;
    logic             dir;
  } item_t;

  // one window entry
  typedef struct packed {
    logic [63:0] kmer;
    logic [63:0] hash;
    logic [31:0] rank;
    logic [31:0] pos;
    logic        dir;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT
  } back_state_e;

  // 2k-bit mask, k above 32 saturates
  function automatic logic [63:0] hash_mask(input logic [5:0] k);
    logic [63:0] m;
    m = '1;
    if (k < 6'd32) begin
      m = (64'd1 << {k, 1'b0}) - 64'd1;
    end
    return m;
  endfunction

  // first half of the mixing network
  function automatic logic [63:0] mix_a(input logic [63:0] key, input logic [63:0] m);
    logic [63:0] x;
    x = (~key + (key << 21)) & m;
    x = x ^ (x >> 24);
    x = ((x + (x << 3)) + (x << 8)) & m;
    return x;
  endfunction

  // second half of the mixing network
  function automatic logic [63:0] mix_b(input logic [63:0] key, input logic [63:0] m);
    logic [63:0] x;
    x = key ^ (key >> 14);
    x = ((x + (x << 2)) + (x << 4)) & m;
    x = x ^ (x >> 28);
    x = (x + (x << 31)) & m;
    return x;
  endfunction

endpackage

// File: sv/sliding_window_minimizer.sv
// ----------------------------------------------------------------------------
// sliding_window_minimizer
// Minimizer selection over a sliding window of k-mers.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// cfg       in   cfg_index_i (0 kmer_length, 1 window_size), cfg_data_i
// s_axis    in   tuser seq_start; tdata kmer_fwd, kmer_rev, kmer_rank
// m_axis    out  tlast run_last; tdata min_kmer, min_hash, min_rank, min_pos, min_dir
//
// The front end computes canonical code and hash in two stages, one item per
// cycle unless stalled, into a two-entry queue. The window engine takes a new
// item only when idle and emits at most one result for an item without a
// rescan; a rescan reads the ring twice per entry. Reset is asynchronous and
// clears only control state; the ring holds no reset value. Output stalls
// hold the engine, and through the queue the front end.
// ----------------------------------------------------------------------------
module sliding_window_minimizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [5:0]    cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [159:0]  s_axis_tdata,  // kmer_fwd[63:0], kmer_rev[127:64], kmer_rank[159:128]
  input  logic          s_axis_tuser,  // seq_start
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [199:0]  m_axis_tdata,  // min_kmer, min_hash, min_rank, min_pos, min_dir[192]
  output logic          m_axis_tlast   // run_last
);

  logic [5:0]      klen_q, wsize_q;
  logic            fq_valid, fq_ready, qb_valid, qb_ready;
  swm_pkg::item_t  fq_item, qb_item;
  swm_pkg::entry_t ent;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q  <= 6'd15;
      wsize_q <= 6'd10;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == swm_pkg::RegKmerLen) klen_q <= cfg_data_i;
      if (cfg_index_i == swm_pkg::RegWinSize) wsize_q <= cfg_data_i;
    end
  end

  swm_front u_front (
    .clk_i, .rst_ni,
    .kmer_length_i (klen_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .seq_start_i   (s_axis_tuser),
    .kmer_fwd_i    (s_axis_tdata[63:0]),
    .kmer_rev_i    (s_axis_tdata[127:64]),
    .kmer_rank_i   (s_axis_tdata[159:128]),
    .out_valid_o   (fq_valid),
    .out_ready_i   (fq_ready),
    .out_item_o    (fq_item)
  );

  swm_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (fq_valid), .wr_ready_o (fq_ready), .wr_item_i (fq_item),
    .rd_valid_o (qb_valid), .rd_ready_i (qb_ready), .rd_item_o (qb_item)
  );

  swm_back u_back (
    .clk_i, .rst_ni,
    .window_size_i (wsize_q),
    .in_valid_i    (qb_valid),
    .in_ready_o    (qb_ready),
    .in_item_i     (qb_item),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_entry_o   (ent),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, ent.dir, ent.pos, ent.rank, ent.hash, ent.kmer};

endmodule

// File: sv/swm_front.sv
// ----------------------------------------------------------------------------
// swm_front
// Accepts k-mers, picks the canonical code and hashes it in two stages.
// ----------------------------------------------------------------------------
module swm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        kmer_length_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              seq_start_i,
  input  logic [63:0]       kmer_fwd_i,
  input  logic [63:0]       kmer_rev_i,
  input  logic [31:0]       kmer_rank_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output swm_pkg::item_t    out_item_o
);

  logic           s1_vld_q, s1_vld_d;
  swm_pkg::item_t s1_q;
  logic [63:0]    mask_q;
  logic           s2_vld_q, s2_vld_d;
  swm_pkg::item_t s2_q;
  logic           s2_adv, s1_adv;
  logic           fwd_lt;

  assign fwd_lt = kmer_fwd_i < kmer_rev_i;
  assign s2_adv = !s2_vld_q || out_ready_i;
  assign s1_adv = !s1_vld_q || s2_adv;
  assign in_ready_o = s1_adv;
  assign out_valid_o = s2_vld_q;
  assign out_item_o = s2_q;

  assign s1_vld_d = s1_adv ? in_valid_i : s1_vld_q;
  assign s2_vld_d = s2_adv ? s1_vld_q : s2_vld_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  // payload stages: canonical code plus first hash half, then second half
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      mask_q          <= swm_pkg::hash_mask(kmer_length_i);
      s1_q.seq_start  <= seq_start_i;
      s1_q.kmer       <= fwd_lt ? kmer_fwd_i : kmer_rev_i;
      s1_q.hash       <= swm_pkg::mix_a(fwd_lt ? kmer_fwd_i : kmer_rev_i,
                                        swm_pkg::hash_mask(kmer_length_i));
      s1_q.rank       <= kmer_rank_i;
      s1_q.dir        <= !fwd_lt;
    end
    if (s2_adv && s1_vld_q) begin
      s2_q.seq_start <= s1_q.seq_start;
      s2_q.kmer      <= s1_q.kmer;
      s2_q.hash      <= swm_pkg::mix_b(s1_q.hash, mask_q);
      s2_q.rank      <= s1_q.rank;
      s2_q.dir       <= s1_q.dir;
    end
  end

endmodule

// File: sv/swm_queue.sv
// ----------------------------------------------------------------------------
// swm_queue
// Small FIFO decoupling the front end from the window engine.
// ----------------------------------------------------------------------------
module swm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  swm_pkg::item_t wr_item_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output swm_pkg::item_t rd_item_o
);

  localparam int unsigned PtrW = $clog2(swm_pkg::QDepth);

  swm_pkg::item_t       mem_q [swm_pkg::QDepth];
  logic [PtrW-1:0]      wp_q, rp_q;
  logic [PtrW:0]        cnt_q;
  logic                 do_wr, do_rd;

  assign wr_ready_o = cnt_q != (PtrW+1)'(swm_pkg::QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_item_o  = mem_q[rp_q];
  assign do_wr = wr_valid_i && wr_ready_o;
  assign do_rd = rd_valid_o && rd_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= wp_q + 1'b1;
      if (do_rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_item_i;
  end

endmodule

// File: sv/swm_back.sv
// ----------------------------------------------------------------------------
// swm_back
// Window ring, minimum tracking, rescans and result emission.
// ----------------------------------------------------------------------------
`include "sliding_window_minimizer_macros.svh"

module swm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [5:0]          window_size_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swm_pkg::item_t      in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swm_pkg::entry_t     out_entry_o,
  output logic                out_last_o
);

  localparam int unsigned SW = swm_pkg::SlotW;
  localparam int unsigned CW = swm_pkg::CntW;

  swm_pkg::back_state_e state_q, state_d;

  swm_pkg::entry_t  ring_q [swm_pkg::MaxWindow];
  swm_pkg::entry_t  rd_q;
  logic [SW-1:0]    rd_addr;

  logic [SW-1:0]    head_q, head_d;
  logic [31:0]      pcnt_q, pcnt_d;
  logic [31:0]      brank_q, brank_d;
  logic [63:0]      bhash_q, bhash_d;
  logic [31:0]      bpos_q, bpos_d;
  swm_pkg::item_t   cur_q;
  logic [31:0]      cpos_q;
  logic [CW-1:0]    w_q;
  logic [CW-1:0]    idx_q, idx_d;
  logic             scan_first_q, scan_first_d;
  logic [CW-1:0]    last_idx_q, last_idx_d;

  logic             ovalid_q, ovalid_d;
  swm_pkg::entry_t  oent_q;
  logic             olast_q;

  logic [CW-1:0]    w_eff;
  logic             take;
  logic [32:0]      filled;
  logic             better;
  logic [32:0]      limit;
  logic             rd_better, rd_equal;
  logic             oslot_free;
  logic             load_out;
  logic             load_new;

  // effective window: 0 means 1, saturate at the ring depth
  always_comb begin
    w_eff = CW'(window_size_i);
    if (window_size_i == '0) w_eff = CW'(1);
    if (window_size_i > 6'(swm_pkg::MaxWindow)) w_eff = CW'(swm_pkg::MaxWindow);
  end

  assign oslot_free = !ovalid_q || out_ready_i;
  assign in_ready_o = state_q == swm_pkg::ST_IDLE;
  assign take       = in_valid_i && in_ready_o;
  assign filled     = {1'b0, cpos_q} + 33'd1;
  assign better     = (cur_q.rank < brank_q) ||
                      ((cur_q.rank == brank_q) && (cur_q.hash <= bhash_q));
  assign limit      = {1'b0, bpos_q} + 33'(w_q);
  assign rd_better  = (rd_q.rank < brank_q) ||
                      ((rd_q.rank == brank_q) && (rd_q.hash < bhash_q));
  assign rd_equal   = (rd_q.rank == brank_q) && (rd_q.hash == bhash_q);
  // window entry idx_d-1 counted from the oldest, so rd_q holds entry idx_q-1
  assign rd_addr    = head_q - SW'(w_q) + SW'(idx_d) - SW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swm_pkg::ST_IDLE:    if (take) state_d = swm_pkg::ST_DECIDE;
      swm_pkg::ST_DECIDE: begin
        if (filled < 33'(w_q)) state_d = swm_pkg::ST_IDLE;
        else if (filled == 33'(w_q)) state_d = swm_pkg::ST_SCAN;
        else if (better) state_d = oslot_free ? swm_pkg::ST_IDLE : swm_pkg::ST_DECIDE;
        else if ({1'b0, cpos_q} >= limit) state_d = swm_pkg::ST_SCAN;
        else state_d = swm_pkg::ST_IDLE;
      end
      swm_pkg::ST_SCAN:
        if (idx_q == w_q) state_d = swm_pkg::ST_EMIT_RD;
      swm_pkg::ST_EMIT_RD: state_d = swm_pkg::ST_EMIT;
      swm_pkg::ST_EMIT: begin
        if (!rd_equal || oslot_free) begin
          state_d = (idx_q == w_q) ? swm_pkg::ST_IDLE : swm_pkg::ST_EMIT;
        end
      end
      default: state_d = swm_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    head_d       = head_q;
    pcnt_d       = pcnt_q;
    brank_d      = brank_q;
    bhash_d      = bhash_q;
    bpos_d       = bpos_q;
    idx_d        = idx_q;
    scan_first_d = scan_first_q;
    last_idx_d   = last_idx_q;
    ovalid_d     = ovalid_q && !out_ready_i;
    load_out     = 1'b0;
    load_new     = 1'b0;
    case (state_q)
      swm_pkg::ST_IDLE: begin
        if (take) begin
          load_new = 1'b1;
          if (in_item_i.seq_start) begin
            head_d  = SW'(1);
            pcnt_d  = 32'd1;
            brank_d = '0;
            bhash_d = '0;
            bpos_d  = '0;
          end else begin
            head_d = head_q + 1'b1;
            if (pcnt_q != '1) pcnt_d = pcnt_q + 32'd1;
          end
        end
      end
      swm_pkg::ST_DECIDE: begin
        idx_d        = '0;
        scan_first_d = 1'b1;
        if (filled > 33'(w_q) && better && oslot_free) begin
          load_out = 1'b1;
          ovalid_d = 1'b1;
          brank_d  = cur_q.rank;
          bhash_d  = cur_q.hash;
          bpos_d   = cpos_q;
        end
      end
      swm_pkg::ST_SCAN: begin
        // rd_q holds entry idx_q-1 once idx_q > 0
        if (idx_q != '0) begin
          if (scan_first_q || rd_better) begin
            brank_d    = rd_q.rank;
            bhash_d    = rd_q.hash;
            last_idx_d = idx_q - CW'(1);
          end else if (rd_equal) begin
            last_idx_d = idx_q - CW'(1);
          end
          scan_first_d = 1'b0;
        end
        idx_d = (idx_q == w_q) ? '0 : idx_q + CW'(1);
      end
      swm_pkg::ST_EMIT_RD: idx_d = idx_q + CW'(1);
      swm_pkg::ST_EMIT: begin
        if (!rd_equal || oslot_free) begin
          if (rd_equal) begin
            load_out = 1'b1;
            ovalid_d = 1'b1;
            bpos_d   = rd_q.pos;
          end
          if (idx_q != w_q) idx_d = idx_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= swm_pkg::ST_IDLE;
      head_q       <= '0;
      pcnt_q       <= '0;
      brank_q      <= '0;
      bhash_q      <= '0;
      bpos_q       <= '0;
      idx_q        <= '0;
      scan_first_q <= 1'b1;
      last_idx_q   <= '0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      pcnt_q       <= pcnt_d;
      brank_q      <= brank_d;
      bhash_q      <= bhash_d;
      bpos_q       <= bpos_d;
      idx_q        <= idx_d;
      scan_first_q <= scan_first_d;
      last_idx_q   <= last_idx_d;
      ovalid_q     <= ovalid_d;
    end
  end

  // ring memory, item capture and output register
  always_ff @(posedge clk_i) begin
    if (load_new) begin
      ring_q[in_item_i.seq_start ? SW'(0) : head_q] <=
        '{kmer: in_item_i.kmer, hash: in_item_i.hash, rank: in_item_i.rank,
          pos: in_item_i.seq_start ? 32'd0 : pcnt_q, dir: in_item_i.dir};
      cur_q  <= in_item_i;
      cpos_q <= in_item_i.seq_start ? 32'd0 : pcnt_q;
      w_q    <= w_eff;
    end
    rd_q <= ring_q[rd_addr];
    if (load_out) begin
      if (state_q == swm_pkg::ST_DECIDE) begin
        oent_q  <= '{kmer: cur_q.kmer, hash: cur_q.hash, rank: cur_q.rank,
                     pos: cpos_q, dir: cur_q.dir};
        olast_q <= 1'b1;
      end else begin
        oent_q  <= rd_q;
        olast_q <= (idx_q - CW'(1)) == last_idx_q;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_entry_o = oent_q;
  assign out_last_o  = olast_q;

  `SWM_ASSERT_IMP(a_no_take_busy, state_q != swm_pkg::ST_IDLE, !in_ready_o, "ready while busy")
  `SWM_ASSERT_NEXT(a_hold_out, ovalid_q && !out_ready_i, ovalid_q && $stable(oent_q), "result dropped")
  `SWM_ASSERT_IMP(a_idx_range, state_q != swm_pkg::ST_IDLE && state_q != swm_pkg::ST_DECIDE, idx_q <= w_q, "index overrun")
  `SWM_ASSERT_NEXT(a_take_decide, take, state_q == swm_pkg::ST_DECIDE, "item not decided")

endmodule
